// ----- rtl/spq_pkg.sv -----
// Shared opcodes, status codes and command flag type for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

	// Opcodes of an input word
	localparam logic [1:0] OPC_PUSH  = 2'd0;
	localparam logic [1:0] OPC_POP   = 2'd1;
	localparam logic [1:0] OPC_CLEAR = 2'd2;

	// Status codes of a result word
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Decoded command; all flags low means no operation
	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} cmd_flags_t;

endpackage

// ----- rtl/spq_front.sv -----
// Front end: accepts input words, decodes the opcode and buffers commands for the back end.
`timescale 1ns / 1ps

module spq_front import spq_pkg::*; #(
	parameter int KEY_BITS  = 16,
	parameter int DATA_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           opcode,
	input  logic [DATA_BITS-1:0] item_data,
	input  logic [KEY_BITS-1:0]  item_key,
	output logic                 cmd_valid,
	input  logic                 cmd_take,
	output cmd_flags_t           cmd_flags,
	output logic [DATA_BITS-1:0] cmd_data,
	output logic [KEY_BITS-1:0]  cmd_key
);

	cmd_flags_t           dec_flags;
	cmd_flags_t           flags_q [2];
	logic [DATA_BITS-1:0] data_q  [2];
	logic [KEY_BITS-1:0]  key_q   [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           cnt_q;
	logic                 wr_en;

	always_comb begin
		dec_flags = '0;
		unique case (opcode)
			OPC_PUSH:  dec_flags.push  = 1'b1;
			OPC_POP:   dec_flags.pop   = 1'b1;
			OPC_CLEAR: dec_flags.clear = 1'b1;
			default:   dec_flags       = '0;
		endcase
	end

	assign in_stall  = (cnt_q == 2'd2);
	assign wr_en     = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd_flags = flags_q[rd_ptr_q];
	assign cmd_data  = data_q[rd_ptr_q];
	assign cmd_key   = key_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			flags_q[wr_ptr_q] <= dec_flags;
			data_q[wr_ptr_q]  <= item_data;
			key_q[wr_ptr_q]   <= item_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en)
				wr_ptr_q <= !wr_ptr_q;
			if (cmd_take)
				rd_ptr_q <= !rd_ptr_q;
			priority if (wr_en && !cmd_take)
				cnt_q <= cnt_q + 2'd1;
			else if (!wr_en && cmd_take)
				cnt_q <= cnt_q - 2'd1;
			else
				cnt_q <= cnt_q;
		end
	end

endmodule

// ----- rtl/spq_back.sv -----
// Back end: row of sorted compare-and-shift cells and the registered result word.
`timescale 1ns / 1ps

module spq_back import spq_pkg::*; #(
	parameter int QUEUE_DEPTH = 64,
	parameter int KEY_BITS    = 16,
	parameter int DATA_BITS   = 32,
	parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_take,
	input  cmd_flags_t           cmd_flags,
	input  logic [DATA_BITS-1:0] cmd_data,
	input  logic [KEY_BITS-1:0]  cmd_key,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 popped_valid,
	output logic [DATA_BITS-1:0] popped_data,
	output logic [KEY_BITS-1:0]  popped_key,
	output logic [DATA_BITS-1:0] head_data,
	output logic [KEY_BITS-1:0]  head_key,
	output logic [CNT_W-1:0]     entry_count,
	output logic                 queue_empty,
	output logic [1:0]           status
);

	logic [KEY_BITS-1:0]  keys_q [QUEUE_DEPTH];
	logic [DATA_BITS-1:0] data_q [QUEUE_DEPTH];
	logic [KEY_BITS-1:0]  nk     [QUEUE_DEPTH];
	logic [DATA_BITS-1:0] nd     [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] gt;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_nx;
	logic                 full;
	logic                 empty;
	logic                 do_push;
	logic                 do_pop;
	logic                 out_valid_q;

	logic                 popped_valid_q;
	logic [DATA_BITS-1:0] popped_data_q;
	logic [KEY_BITS-1:0]  popped_key_q;
	logic [DATA_BITS-1:0] head_data_q;
	logic [KEY_BITS-1:0]  head_key_q;
	logic [CNT_W-1:0]     entry_count_q;
	logic                 queue_empty_q;
	logic [1:0]           status_q;

	assign cmd_take = cmd_valid && (!out_valid_q || !out_stall);
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = cmd_take && cmd_flags.push && !full;
	assign do_pop   = cmd_take && cmd_flags.pop && !empty;

	// A cell lies behind the insertion point if it is unused or holds a larger key
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++)
			gt[i] = (CNT_W'(i) >= count_q) || (keys_q[i] > cmd_key);
	end

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		logic [KEY_BITS-1:0]  up_k;
		logic [DATA_BITS-1:0] up_d;
		logic [KEY_BITS-1:0]  dn_k;
		logic [DATA_BITS-1:0] dn_d;
		logic                 prev_gt;

		if (g == 0) begin : g_first
			assign up_k    = cmd_key;
			assign up_d    = cmd_data;
			assign prev_gt = 1'b0;
		end else begin : g_mid
			assign up_k    = keys_q[g-1];
			assign up_d    = data_q[g-1];
			assign prev_gt = gt[g-1];
		end

		if (g == QUEUE_DEPTH - 1) begin : g_last
			assign dn_k = keys_q[g];
			assign dn_d = data_q[g];
		end else begin : g_inner
			assign dn_k = keys_q[g+1];
			assign dn_d = data_q[g+1];
		end

		// Push: shift up behind the insertion point, load the new word at it.
		// Pop: advance every cell toward the head.
		always_comb begin
			nk[g] = keys_q[g];
			nd[g] = data_q[g];
			priority if (do_push && gt[g]) begin
				if (prev_gt) begin
					nk[g] = up_k;
					nd[g] = up_d;
				end else begin
					nk[g] = cmd_key;
					nd[g] = cmd_data;
				end
			end else if (do_pop) begin
				nk[g] = dn_k;
				nd[g] = dn_d;
			end else begin
				nk[g] = keys_q[g];
				nd[g] = data_q[g];
			end
		end
	end

	always_comb begin
		count_nx = count_q;
		priority if (cmd_take && cmd_flags.clear)
			count_nx = '0;
		else if (do_push)
			count_nx = count_q + CNT_W'(1);
		else if (do_pop)
			count_nx = count_q - CNT_W'(1);
		else
			count_nx = count_q;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			keys_q[i] <= nk[i];
			data_q[i] <= nd[i];
		end
		if (cmd_take) begin
			popped_valid_q <= do_pop;
			popped_data_q  <= do_pop ? data_q[0] : '0;
			popped_key_q   <= do_pop ? keys_q[0] : '0;
			head_data_q    <= (count_nx != '0) ? nd[0] : '0;
			head_key_q     <= (count_nx != '0) ? nk[0] : '0;
			entry_count_q  <= count_nx;
			queue_empty_q  <= (count_nx == '0);
			priority if (cmd_flags.push && full)
				status_q <= ST_FULL;
			else if (cmd_flags.pop && empty)
				status_q <= ST_EMPTY;
			else
				status_q <= ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nx;
			if (cmd_take)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign popped_valid = popped_valid_q;
	assign popped_data  = popped_data_q;
	assign popped_key   = popped_key_q;
	assign head_data    = head_data_q;
	assign head_key     = head_key_q;
	assign entry_count  = entry_count_q;
	assign queue_empty  = queue_empty_q;
	assign status       = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (keys_q[0] <= keys_q[1]))
		else $error("head cells out of key order");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("accepted push did not grow the count");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (queue_empty_q == (entry_count_q == '0)))
		else $error("empty flag disagrees with reported count");

	a_pop_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && popped_valid_q) |-> (status_q == ST_OK))
		else $error("popped word carries an error status");

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: command front end, buffer and cell row back end.
`timescale 1ns / 1ps

// Bounded priority queue of QUEUE_DEPTH entries kept in ascending key order
// in a row of compare-and-shift cells; the lowest key is served first and
// equal keys leave in arrival order. Each input word is a push (opcode 0),
// a pop (1) or a clear (2); opcode 3 does nothing. Every input word gives
// exactly one result word with the popped entry, the head after the
// operation, the entry count, an empty flag and a status (0 ok, 1 pop on an
// empty queue, 2 push dropped because the queue was full). The front end
// decodes words into a two-entry command buffer; the back end executes one
// command per cycle, all cells compare against the key in parallel, so the
// block sustains one word per cycle while the result side keeps up. The
// result word passes through the command buffer register and then the
// result register before it is offered. A stalled result word holds the
// back end; the front end then absorbs up to two more words before it
// stalls its input. Head fields read zero when the queue is empty and
// popped fields read zero when nothing was popped.
module sorted_priority_queue import spq_pkg::*; #(
	parameter int QUEUE_DEPTH = 64,
	parameter int KEY_BITS    = 16,
	parameter int DATA_BITS   = 32,
	localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,

	// input word channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           opcode,
	input  logic [DATA_BITS-1:0] item_data,
	input  logic [KEY_BITS-1:0]  item_key,

	// result word channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 popped_valid,
	output logic [DATA_BITS-1:0] popped_data,
	output logic [KEY_BITS-1:0]  popped_key,
	output logic [DATA_BITS-1:0] head_data,
	output logic [KEY_BITS-1:0]  head_key,
	output logic [CNT_W-1:0]     entry_count,
	output logic                 queue_empty,
	output logic [1:0]           status
);

	// Command path between front and back end
	logic                 cmd_valid;
	logic                 cmd_take;
	cmd_flags_t           cmd_flags;
	logic [DATA_BITS-1:0] cmd_data;
	logic [KEY_BITS-1:0]  cmd_key;

	// Decode and buffer incoming words; stall only when both slots hold commands
	spq_front #(
		.KEY_BITS  (KEY_BITS),
		.DATA_BITS (DATA_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.item_data (item_data),
		.item_key  (item_key),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd_flags (cmd_flags),
		.cmd_data  (cmd_data),
		.cmd_key   (cmd_key)
	);

	// Execute one command per cycle whenever the result register is free
	spq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.KEY_BITS    (KEY_BITS),
		.DATA_BITS   (DATA_BITS),
		.CNT_W       (CNT_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_take     (cmd_take),
		.cmd_flags    (cmd_flags),
		.cmd_data     (cmd_data),
		.cmd_key      (cmd_key),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.popped_valid (popped_valid),
		.popped_data  (popped_data),
		.popped_key   (popped_key),
		.head_data    (head_data),
		.head_key     (head_key),
		.entry_count  (entry_count),
		.queue_empty  (queue_empty),
		.status       (status)
	);

endmodule

// ----- test/spq_checker.sv -----
// Checker for the sorted priority queue: tracks the queue contents and compares result words.
`timescale 1ns / 1ps

module spq_checker import spq_pkg::*; #(
	parameter int QUEUE_DEPTH = 64,
	parameter int KEY_BITS    = 16,
	parameter int DATA_BITS   = 32,
	parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [1:0]           opcode,
	input  logic [DATA_BITS-1:0] item_data,
	input  logic [KEY_BITS-1:0]  item_key,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 popped_valid,
	input  logic [DATA_BITS-1:0] popped_data,
	input  logic [KEY_BITS-1:0]  popped_key,
	input  logic [DATA_BITS-1:0] head_data,
	input  logic [KEY_BITS-1:0]  head_key,
	input  logic [CNT_W-1:0]     entry_count,
	input  logic                 queue_empty,
	input  logic [1:0]           status,
	output int                   error_count,
	output int                   pending_count,
	output int                   words_checked,
	output int                   full_drops,
	output int                   empty_pops
);

	typedef struct packed {
		logic                 popped_valid;
		logic [DATA_BITS-1:0] popped_data;
		logic [KEY_BITS-1:0]  popped_key;
		logic [DATA_BITS-1:0] head_data;
		logic [KEY_BITS-1:0]  head_key;
		logic [CNT_W-1:0]     entry_count;
		logic                 queue_empty;
		logic [1:0]           status;
	} queue_result_t;

	// sorted copy of the queue, lowest key at index 0
	logic [DATA_BITS-1:0] held_data [QUEUE_DEPTH];
	logic [KEY_BITS-1:0]  held_key  [QUEUE_DEPTH];
	int                   held_count;

	queue_result_t due_results [$];
	int n_fail, n_words, n_full, n_empty;

	task automatic report(input string what);
		$display("ERROR at %0t, result word %0d: %s", $time, n_words, what);
		n_fail++;
	endtask

	// apply one input word to the queue copy and return the result it causes
	function automatic queue_result_t next_queue_result(input logic [1:0] op,
			input logic [DATA_BITS-1:0] data, input logic [KEY_BITS-1:0] key);
		queue_result_t r;
		int pos;
		int i;
		r = '0;
		r.status = ST_OK;
		case (op)
			OPC_PUSH: begin
				if (held_count >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// equal keys go behind the ones already stored
					pos = 0;
					while (pos < held_count && held_key[pos] <= key)
						pos++;
					for (i = held_count; i > pos; i--) begin
						held_key[i]  = held_key[i-1];
						held_data[i] = held_data[i-1];
					end
					held_key[pos]  = key;
					held_data[pos] = data;
					held_count++;
				end
			end
			OPC_POP: begin
				if (held_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.popped_valid = 1'b1;
					r.popped_data  = held_data[0];
					r.popped_key   = held_key[0];
					for (i = 1; i < held_count; i++) begin
						held_key[i-1]  = held_key[i];
						held_data[i-1] = held_data[i];
					end
					held_count--;
				end
			end
			OPC_CLEAR: held_count = 0;
			default: ;
		endcase
		if (held_count > 0) begin
			r.head_data = held_data[0];
			r.head_key  = held_key[0];
		end
		r.entry_count = CNT_W'(held_count);
		r.queue_empty = (held_count == 0);
		return r;
	endfunction

	task automatic check_result();
		queue_result_t want;
		if (due_results.size() == 0) begin
			report("result word arrived with nothing outstanding");
			return;
		end
		want = due_results.pop_front();
		if (popped_valid !== want.popped_valid)
			report($sformatf("popped_valid %0h, want %0h", popped_valid, want.popped_valid));
		if (popped_data !== want.popped_data)
			report($sformatf("popped_data %0h, want %0h", popped_data, want.popped_data));
		if (popped_key !== want.popped_key)
			report($sformatf("popped_key %0h, want %0h", popped_key, want.popped_key));
		if (head_data !== want.head_data)
			report($sformatf("head_data %0h, want %0h", head_data, want.head_data));
		if (head_key !== want.head_key)
			report($sformatf("head_key %0h, want %0h", head_key, want.head_key));
		if (entry_count !== want.entry_count)
			report($sformatf("entry_count %0d, want %0d", entry_count, want.entry_count));
		if (queue_empty !== want.queue_empty)
			report($sformatf("queue_empty %0h, want %0h", queue_empty, want.queue_empty));
		if (status !== want.status)
			report($sformatf("status %0d, want %0d", status, want.status));
	endtask

	// predict before comparing so a same-edge word is found in the queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			due_results.delete();
			n_fail  = 0;
			n_words = 0;
			n_full  = 0;
			n_empty = 0;
			error_count   <= 0;
			pending_count <= 0;
			words_checked <= 0;
			full_drops    <= 0;
			empty_pops    <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				due_results.push_back(next_queue_result(opcode, item_data, item_key));
				if (due_results[$].status == ST_FULL)
					n_full++;
				if (due_results[$].status == ST_EMPTY)
					n_empty++;
			end
			if (out_valid && !out_stall) begin
				check_result();
				n_words++;
			end
			error_count   <= n_fail;
			pending_count <= due_results.size();
			words_checked <= n_words;
			full_drops    <= n_full;
			empty_pops    <= n_empty;
		end
	end

endmodule

// ----- test/tb.sv -----
// Testbench top for the sorted priority queue: clock, reset, word traffic and verdict.
`timescale 1ns / 1ps

module tb;
	import spq_pkg::*;

	localparam int QUEUE_DEPTH  = 64;
	localparam int KEY_BITS     = 16;
	localparam int DATA_BITS    = 32;
	localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int RANDOM_WORDS = 1500;
	// cycles the receiver refuses words during a backpressure phase
	localparam int LONG_HOLD    = 150;
	// no word moving for this long means the block hung
	localparam int IDLE_LIMIT   = 2000;
	// covers the result path plus margin for stray words at the end
	localparam int DRAIN_CYCLES = 8;
	// opcode 3 is unused by the block and must change nothing
	localparam logic [1:0] OPC_NOP = 2'd3;

	typedef enum int {PH_PRESSURE, PH_FILL, PH_DRAIN, PH_PAUSE, PH_MIXED} phase_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           opcode;
	logic [DATA_BITS-1:0] item_data;
	logic [KEY_BITS-1:0]  item_key;
	logic                 out_valid;
	logic                 out_stall;
	logic                 popped_valid;
	logic [DATA_BITS-1:0] popped_data;
	logic [KEY_BITS-1:0]  popped_key;
	logic [DATA_BITS-1:0] head_data;
	logic [KEY_BITS-1:0]  head_key;
	logic [CNT_W-1:0]     entry_count;
	logic                 queue_empty;
	logic [1:0]           status;

	int error_count, pending_count, words_checked, full_drops, empty_pops;

	// sender runs back to back while set
	bit send_eager;
	// long receiver hold-offs requested and served
	int hold_asks;
	int hold_done;
	int idle_run;
	int phase_no;

	sorted_priority_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.KEY_BITS    (KEY_BITS),
		.DATA_BITS   (DATA_BITS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.item_data    (item_data),
		.item_key     (item_key),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.popped_valid (popped_valid),
		.popped_data  (popped_data),
		.popped_key   (popped_key),
		.head_data    (head_data),
		.head_key     (head_key),
		.entry_count  (entry_count),
		.queue_empty  (queue_empty),
		.status       (status)
	);

	spq_checker #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.KEY_BITS    (KEY_BITS),
		.DATA_BITS   (DATA_BITS)
	) u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.item_data     (item_data),
		.item_key      (item_key),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.popped_valid  (popped_valid),
		.popped_data   (popped_data),
		.popped_key    (popped_key),
		.head_data     (head_data),
		.head_key      (head_key),
		.entry_count   (entry_count),
		.queue_empty   (queue_empty),
		.status        (status),
		.error_count   (error_count),
		.pending_count (pending_count),
		.words_checked (words_checked),
		.full_drops    (full_drops),
		.empty_pops    (empty_pops)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Keys: a narrow low band to force ties, the two extremes, a band near the
	// top, and fully random values so every key bit toggles.
	function automatic logic [KEY_BITS-1:0] pick_key();
		case ($urandom_range(0, 3))
			0: return KEY_BITS'($urandom_range(0, 7));
			1: return $urandom_range(0, 1) ? '1 : '0;
			2: return KEY_BITS'(16'hFFF8 + $urandom_range(0, 7));
			default: return KEY_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [DATA_BITS-1:0] pick_data();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return DATA_BITS'($urandom);
		endcase
	endfunction

	// Offer one word after a random gap and hold it until the block takes it.
	// Valid is raised once per step and the payload stays put while stalled.
	task automatic send_word(input logic [1:0] op, input logic [DATA_BITS-1:0] data,
			input logic [KEY_BITS-1:0] key);
		int gap;
		gap = $urandom_range(0, 15);
		if (send_eager)
			gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		item_data <= data;
		item_key  <= key;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drop valid and hold until the checker has seen every outstanding result.
	// The first edge lets the count pick up the word accepted right now.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
	endtask

	// Receiver: draw a stall length per result word, with stretches of no
	// stalling, and serve any long hold-off the stimulus asks for.
	initial begin
		int  wait_cycles;
		bit  recv_eager;
		recv_eager = 1'b0;
		out_stall  = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_asks != hold_done) begin
				hold_done++;
				wait_cycles = LONG_HOLD;
			end else begin
				wait_cycles = $urandom_range(0, 15);
				if (recv_eager)
					wait_cycles = 0;
			end
			if ($urandom_range(0, 49) == 0)
				recv_eager = !recv_eager;
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// Watchdog: end the run when no word moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_run <= 0;
		end else if (idle_run >= IDLE_LIMIT) begin
			$display("ERROR: no word moved for %0d cycles", IDLE_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_run <= idle_run + 1;
		end
	end

	initial begin
		int         sent;
		int         i;
		int         r;
		phase_t     kind;
		logic [1:0] op;

		// all inputs known from time zero, reset asserted until released at a clock edge
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		opcode     = OPC_PUSH;
		item_data  = '0;
		item_key   = '0;
		send_eager = 1'b0;
		hold_asks  = 0;
		hold_done  = 0;
		idle_run   = 0;
		phase_no   = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-queue pop, unused opcode and clear on an empty queue,
		// extreme keys and payloads, ties on both extreme keys, the unused
		// opcode on a filled queue, draining past empty, and a clear of a
		// filled queue followed by a pop.
		send_word(OPC_POP,   pick_data(),      pick_key());
		send_word(OPC_NOP,   pick_data(),      pick_key());
		send_word(OPC_CLEAR, pick_data(),      pick_key());
		send_word(OPC_PUSH,  32'h0000_0000,    16'hFFFF);
		send_word(OPC_PUSH,  32'hFFFF_FFFF,    16'h0000);
		send_word(OPC_PUSH,  32'h1111_1111,    16'h0000);
		send_word(OPC_PUSH,  32'h2222_2222,    16'hFFFF);
		send_word(OPC_PUSH,  32'h3333_3333,    16'h8000);
		send_word(OPC_NOP,   pick_data(),      pick_key());
		send_word(OPC_PUSH,  32'hAAAA_AAAA,    16'h7FFF);
		for (i = 0; i < 7; i++)
			send_word(OPC_POP, pick_data(), pick_key());
		send_word(OPC_PUSH,  32'h5555_5555,    16'h5555);
		send_word(OPC_PUSH,  32'hAAAA_AAAA,    16'hAAAA);
		send_word(OPC_CLEAR, pick_data(),      pick_key());
		send_word(OPC_POP,   pick_data(),      pick_key());
		send_word(OPC_PUSH,  32'h8000_0001,    16'h0001);
		send_word(OPC_POP,   pick_data(),      pick_key());

		// Random phases: the first four run each special phase once, then mixed
		// traffic dominates with pressure, fill, drain and pause runs between.
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			r = $urandom_range(0, 7);
			if (phase_no < 4)
				kind = phase_t'(phase_no);
			else
				kind = (r < 4) ? phase_t'(r) : PH_MIXED;
			send_eager = ($urandom_range(0, 2) == 0);
			case (kind)
				PH_PRESSURE: begin
					// starve the output so the block backs up into its input
					hold_asks++;
					send_eager = 1'b1;
					for (i = 0; i < 80; i++)
						send_word(OPC_PUSH, pick_data(), pick_key());
					sent += 80;
				end
				PH_FILL: begin
					// enough pushes to fill from any level and overflow
					for (i = 0; i < QUEUE_DEPTH + 6; i++)
						send_word(OPC_PUSH, pick_data(), pick_key());
					sent += QUEUE_DEPTH + 6;
				end
				PH_DRAIN: begin
					for (i = 0; i < QUEUE_DEPTH + 6; i++)
						send_word(OPC_POP, pick_data(), pick_key());
					sent += QUEUE_DEPTH + 6;
				end
				PH_PAUSE: wait_for_results();
				default: begin
					for (i = 0; i < 40; i++) begin
						r = $urandom_range(0, 99);
						if (r < 50)
							op = OPC_PUSH;
						else if (r < 90)
							op = OPC_POP;
						else if (r < 94)
							op = OPC_CLEAR;
						else
							op = OPC_NOP;
						send_word(op, pick_data(), pick_key());
						if (op != OPC_NOP)
							sent++;
					end
				end
			endcase
			phase_no++;
		end

		// drain everything outstanding, then allow for late stray words
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run checked %0d result words across %0d traffic phases.",
			words_checked, phase_no);
		$display("It hit %0d pushes into a full queue and %0d pops from an empty one.",
			full_drops, empty_pops);
		if (error_count == 0 && pending_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- sorted_priority_queue.f -----
rtl/spq_pkg.sv
rtl/spq_front.sv
rtl/spq_back.sv
rtl/sorted_priority_queue.sv
test/spq_checker.sv
test/tb.sv
